>>> sv/wmrs_pkg.sv
// ----------------------------------------------------------------------------
// wmrs_pkg
// Shared types and constants for the weighted masked ratio scaling block.
// ----------------------------------------------------------------------------
`default_nettype none

package wmrs_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int WEIGHT_W  = 17;
    localparam int PROD_W    = WEIGHT_W + SAMPLE_W - 1;
    localparam int ACC_W     = 64;
    localparam int SCALE_W   = 32;
    localparam int FRAC_W    = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SCALE_W-1:0] SCALE_MAX = '1;

    // One finished run: both sums, handed from the accumulator to the divider.
    typedef struct packed {
        logic [ACC_W-1:0] num;
        logic [ACC_W-1:0] den;
    } t_sums;

endpackage

`default_nettype wire

>>> sv/weighted_masked_ratio_scaling.sv
// ----------------------------------------------------------------------------
// weighted_masked_ratio_scaling
// Weighted sums of unmasked slice and pattern pixels, reported per run as an
// unsigned Q16.16 ratio with zero-denominator and saturation flags.
// ----------------------------------------------------------------------------
//   channel   handshake           payload
//   pixel in  i_valid / o_ready   i_pattern_value, i_slice_value, i_weight, i_last
//   ratio out o_valid / i_ready   o_scale, o_zero_denominator, o_saturated
//
// Pixels are taken one per cycle, unless the input stalls, into a product
// register, then added into the saturating sums; a run end pushes both sums
// into a two-entry queue. The divider screens the sums, forms the quotient
// bits (a 64-bit compare and subtract each) and then loads the output; a zero
// or overflowing ratio skips the quotient bits. Input stalls only when a run
// end finds the queue full. Reset clears the sums, the queue and the output
// valid.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_masked_ratio_scaling (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic signed [wmrs_pkg::SAMPLE_W-1:0] i_pattern_value,
    input  wire logic signed [wmrs_pkg::SAMPLE_W-1:0] i_slice_value,
    input  wire logic        [wmrs_pkg::WEIGHT_W-1:0] i_weight,
    input  wire logic                                 i_last,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic             [wmrs_pkg::SCALE_W-1:0]  o_scale,
    output logic                                      o_zero_denominator,
    output logic                                      o_saturated
);

    logic            q_full;
    logic            q_empty;
    logic            q_push;
    logic            q_pop;
    wmrs_pkg::t_sums q_push_data;
    wmrs_pkg::t_sums q_pop_data;

    wmrs_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_pattern_value (i_pattern_value),
        .i_slice_value   (i_slice_value),
        .i_weight        (i_weight),
        .i_last          (i_last),
        .i_full          (q_full),
        .o_push          (q_push),
        .o_push_data     (q_push_data)
    );

    wmrs_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_pop_data  (q_pop_data),
        .o_empty     (q_empty)
    );

    wmrs_divider u_divider (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_empty            (q_empty),
        .i_pop_data         (q_pop_data),
        .o_pop              (q_pop),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_scale            (o_scale),
        .o_zero_denominator (o_zero_denominator),
        .o_saturated        (o_saturated)
    );

endmodule

`default_nettype wire

>>> sv/wmrs_front.sv
// ----------------------------------------------------------------------------
// wmrs_front
// Accepts pixel words, forms weighted products of unmasked pixels and keeps
// the two saturating run sums. At the end of a run it pushes both sums.
// ----------------------------------------------------------------------------
`default_nettype none

module wmrs_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic signed [wmrs_pkg::SAMPLE_W-1:0] i_pattern_value,
    input  wire logic signed [wmrs_pkg::SAMPLE_W-1:0] i_slice_value,
    input  wire logic        [wmrs_pkg::WEIGHT_W-1:0] i_weight,
    input  wire logic                               i_last,
    input  wire logic                               i_full,
    output logic                                    o_push,
    output wmrs_pkg::t_sums                         o_push_data
);

    localparam int PW = wmrs_pkg::PROD_W;
    localparam int AW = wmrs_pkg::ACC_W;

    logic          r_p_valid;
    logic          r_p_last;
    logic [PW-1:0] r_p_slc;
    logic [PW-1:0] r_p_pat;
    logic [AW-1:0] r_slc_acc;
    logic [AW-1:0] r_pat_acc;

    logic          advance;
    logic          take;
    logic          keep;
    logic [AW:0]   slc_sum;
    logic [AW:0]   pat_sum;
    logic [AW-1:0] n_slc_acc;
    logic [AW-1:0] n_pat_acc;

    // Hold the product stage while a run end waits for queue room.
    assign advance = r_p_valid && (!r_p_last || !i_full);
    assign o_ready = !r_p_valid || advance;
    assign take    = i_valid && o_ready;
    assign keep    = !i_pattern_value[wmrs_pkg::SAMPLE_W-1]
                  && !i_slice_value[wmrs_pkg::SAMPLE_W-1];

    assign slc_sum = {1'b0, r_slc_acc} + (AW+1)'(r_p_slc);
    assign pat_sum = {1'b0, r_pat_acc} + (AW+1)'(r_p_pat);

    // Clamp at all ones instead of wrapping.
    assign n_slc_acc = slc_sum[AW] ? '1 : slc_sum[AW-1:0];
    assign n_pat_acc = pat_sum[AW] ? '1 : pat_sum[AW-1:0];

    assign o_push          = advance && r_p_last;
    assign o_push_data.num = n_slc_acc;
    assign o_push_data.den = n_pat_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_slc_acc <= '0;
            r_pat_acc <= '0;
        end else begin
            if (take) begin
                r_p_valid <= 1'b1;
            end else if (advance) begin
                r_p_valid <= 1'b0;
            end
            if (advance) begin
                r_slc_acc <= r_p_last ? '0 : n_slc_acc;
                r_pat_acc <= r_p_last ? '0 : n_pat_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_p_last <= i_last;
            if (keep) begin
                r_p_slc <= PW'(i_weight) * PW'(i_slice_value[wmrs_pkg::SAMPLE_W-2:0]);
                r_p_pat <= PW'(i_weight) * PW'(i_pattern_value[wmrs_pkg::SAMPLE_W-2:0]);
            end else begin
                r_p_slc <= '0;
                r_p_pat <= '0;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/wmrs_queue.sv
// ----------------------------------------------------------------------------
// wmrs_queue
// Two-entry queue of finished run sums between accumulator and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module wmrs_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire wmrs_pkg::t_sums i_push_data,
    output logic                 o_full,
    input  wire logic            i_pop,
    output wmrs_pkg::t_sums      o_pop_data,
    output logic                 o_empty
);

    localparam int PTR_W = $clog2(wmrs_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(wmrs_pkg::QUEUE_DEPTH + 1);

    wmrs_pkg::t_sums  r_mem [wmrs_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full     = (r_count == CNT_W'(wmrs_pkg::QUEUE_DEPTH));
    assign o_empty    = (r_count == '0);
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

>>> sv/wmrs_divider.sv
// ----------------------------------------------------------------------------
// wmrs_divider
// Takes run sums from the queue, screens the zero and overflow cases and
// forms the Q16.16 ratio one quotient bit per cycle. Drives the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module wmrs_divider (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_empty,
    input  wire wmrs_pkg::t_sums                    i_pop_data,
    output logic                                    o_pop,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [wmrs_pkg::SCALE_W-1:0]            o_scale,
    output logic                                    o_zero_denominator,
    output logic                                    o_saturated
);

    localparam int AW = wmrs_pkg::ACC_W;
    localparam int SW = wmrs_pkg::SCALE_W;
    localparam int FW = wmrs_pkg::FRAC_W;
    localparam int CW = $clog2(SW);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state        r_state;
    t_state        n_state;
    logic [AW-1:0] r_den;
    logic [AW-1:0] r_rem;
    logic [SW-1:0] r_dlo;
    logic [SW-1:0] r_q;
    logic [CW-1:0] r_cnt;
    logic          r_zden;
    logic          r_sat;
    logic          r_o_valid;
    logic [SW-1:0] r_o_scale;
    logic          r_o_zden;
    logic          r_o_sat;

    logic          den_zero;
    logic          too_big;
    logic [AW:0]   trial;
    logic          ge;
    logic          load_out;

    assign den_zero = (i_pop_data.den == '0);
    // Ratio reaches 2^16 only when den fits in 48 bits and num >= den * 2^16.
    assign too_big  = (i_pop_data.den[AW-1:AW-FW] == '0)
                   && (i_pop_data.num >= {i_pop_data.den[AW-FW-1:0], FW'(0)});

    assign trial    = {r_rem, r_dlo[SW-1]};
    assign ge       = (trial >= {1'b0, r_den});
    assign load_out = (r_state == S_DONE) && (!r_o_valid || i_ready);
    assign o_pop    = (r_state == S_IDLE) && !i_empty;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_state = (den_zero || too_big) ? S_DONE : S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == CW'(SW - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_den  <= i_pop_data.den;
                r_rem  <= AW'(i_pop_data.num[AW-1:FW]);
                r_dlo  <= {i_pop_data.num[FW-1:0], (SW-FW)'(0)};
                r_cnt  <= '0;
                r_zden <= den_zero;
                r_sat  <= !den_zero && too_big;
                r_q    <= (den_zero || too_big) ? wmrs_pkg::SCALE_MAX : '0;
            end
            S_DIV: begin
                // Shift in one dividend bit, subtract when it fits.
                r_rem <= ge ? AW'(trial - {1'b0, r_den}) : trial[AW-1:0];
                r_dlo <= {r_dlo[SW-2:0], 1'b0};
                r_q   <= {r_q[SW-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
            end
            S_DONE: begin
                r_q <= r_q;
            end
            default: r_q <= r_q;
        endcase
        if (load_out) begin
            r_o_scale <= r_q;
            r_o_zden  <= r_zden;
            r_o_sat   <= r_sat;
        end
    end

    assign o_valid            = r_o_valid;
    assign o_scale            = r_o_scale;
    assign o_zero_denominator = r_o_zden;
    assign o_saturated        = r_o_sat;

endmodule

`default_nettype wire

>>> verif/weighted_masked_ratio_scaling_test.sv
// ----------------------------------------------------------------------------
// weighted_masked_ratio_scaling_test
// Streams pixel runs into the ratio scaling block with random idle gaps on
// both sides. A scoreboard keeps its own weighted sums, predicts each run's
// Q16.16 ratio and flags, and checks every ratio word in order.
// ----------------------------------------------------------------------------

module weighted_masked_ratio_scaling_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIXEL_COUNT = 800;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES = 400;

    localparam int SAMPLE_W = wmrs_pkg::SAMPLE_W;
    localparam int WEIGHT_W = wmrs_pkg::WEIGHT_W;
    localparam int SCALE_W  = wmrs_pkg::SCALE_W;
    localparam int ACC_W    = wmrs_pkg::ACC_W;
    localparam int FRAC_W   = wmrs_pkg::FRAC_W;

    typedef struct {
        logic signed [SAMPLE_W-1:0] pattern;
        logic signed [SAMPLE_W-1:0] slice;
        logic        [WEIGHT_W-1:0] weight;
        logic                       last;
    } t_pixel;

    typedef struct {
        logic [SCALE_W-1:0] scale;
        logic               zero_den;
        logic               sat;
    } t_ratio;

    class ratio_scoreboard;
        logic [ACC_W-1:0] slice_sum;
        logic [ACC_W-1:0] pattern_sum;
        t_ratio           pending[$];
        int               errors;
        int               pixels;
        int               runs;
        int               zero_dens;
        int               sats;

        function new();
            slice_sum   = '0;
            pattern_sum = '0;
            errors      = 0;
            pixels      = 0;
            runs        = 0;
            zero_dens   = 0;
            sats        = 0;
        endfunction

        // Sum that sticks at all ones instead of wrapping.
        function logic [ACC_W-1:0] add_clamped(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b);
            logic [ACC_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[ACC_W] ? '1 : s[ACC_W-1:0];
        endfunction

        function void note_pixel(t_pixel px);
            t_ratio                   r;
            logic [ACC_W+FRAC_W-1:0]  num_wide;
            logic [ACC_W+FRAC_W-1:0]  den_wide;
            pixels++;
            if (!px.pattern[SAMPLE_W-1] && !px.slice[SAMPLE_W-1]) begin
                slice_sum = add_clamped(slice_sum,
                    {{(ACC_W-WEIGHT_W){1'b0}}, px.weight} *
                    {{(ACC_W-SAMPLE_W){1'b0}}, $unsigned(px.slice)});
                pattern_sum = add_clamped(pattern_sum,
                    {{(ACC_W-WEIGHT_W){1'b0}}, px.weight} *
                    {{(ACC_W-SAMPLE_W){1'b0}}, $unsigned(px.pattern)});
            end
            if (!px.last)
                return;
            r.zero_den = 1'b0;
            r.sat      = 1'b0;
            num_wide   = {slice_sum, {FRAC_W{1'b0}}};
            den_wide   = {{FRAC_W{1'b0}}, pattern_sum};
            if (pattern_sum == '0) begin
                r.scale    = wmrs_pkg::SCALE_MAX;
                r.zero_den = 1'b1;
                zero_dens++;
            end else if ({{FRAC_W{1'b0}}, slice_sum} >= {pattern_sum, {FRAC_W{1'b0}}}) begin
                r.scale = wmrs_pkg::SCALE_MAX;
                r.sat   = 1'b1;
                sats++;
            end else begin
                r.scale = SCALE_W'(num_wide / den_wide);
            end
            pending.push_back(r);
            runs++;
            slice_sum   = '0;
            pattern_sum = '0;
        endfunction

        function void check_ratio(t_ratio got);
            t_ratio want;
            if (pending.size() == 0) begin
                $error("ratio word with none outstanding: scale %h", got.scale);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.scale !== want.scale) begin
                $error("scale: expected %h, got %h", want.scale, got.scale);
                errors++;
            end
            if (got.zero_den !== want.zero_den) begin
                $error("zero_denominator: expected %b, got %b", want.zero_den, got.zero_den);
                errors++;
            end
            if (got.sat !== want.sat) begin
                $error("saturated: expected %b, got %b", want.sat, got.sat);
                errors++;
            end
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic signed [SAMPLE_W-1:0] i_pattern_value;
    logic signed [SAMPLE_W-1:0] i_slice_value;
    logic        [WEIGHT_W-1:0] i_weight;
    logic                       i_last;
    logic                       o_valid;
    logic                       i_ready;
    logic        [SCALE_W-1:0]  o_scale;
    logic                       o_zero_denominator;
    logic                       o_saturated;

    ratio_scoreboard sb = new();
    int              cycle_count = 0;
    int              sent_count = 0;
    int              send_calm = 0;
    int              recv_calm = 0;
    bit              hold_pending = 1'b0;
    bit              hold_done = 1'b0;

    weighted_masked_ratio_scaling dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_pattern_value    (i_pattern_value),
        .i_slice_value      (i_slice_value),
        .i_weight           (i_weight),
        .i_last             (i_last),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_scale            (o_scale),
        .o_zero_denominator (o_zero_denominator),
        .o_saturated        (o_saturated)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Random idle gap before each word, with occasional stretches of back-to-back words.
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 9))
            0:       return {1'b1, 23'($urandom)};
            1:       return '0;
            2:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
            3, 4:    return SAMPLE_W'($urandom_range(0, 255));
            default: return {1'b0, 23'($urandom)};
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] draw_weight();
        case ($urandom_range(0, 7))
            0:       return '0;
            1, 2:    return WEIGHT_W'(65536);
            3:       return WEIGHT_W'($urandom);
            default: return WEIGHT_W'($urandom_range(0, 65536));
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the word was taken.
    task automatic send_pixel(t_pixel px, int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_pattern_value <= px.pattern;
        i_slice_value   <= px.slice;
        i_weight        <= px.weight;
        i_last          <= px.last;
        do @(posedge i_clk); while (!o_ready);
        sb.note_pixel(px);
        sent_count++;
    endtask

    task automatic push(int pat, int slc, int w, bit last);
        t_pixel px;
        px.pattern = SAMPLE_W'(pat);
        px.slice   = SAMPLE_W'(slc);
        px.weight  = WEIGHT_W'(w);
        px.last    = last;
        send_pixel(px, draw_gap(send_calm));
    endtask

    task automatic send_random_run(int len, bit no_gaps);
        t_pixel px;
        for (int k = 0; k < len; k++) begin
            px.pattern = draw_sample();
            px.slice   = draw_sample();
            px.weight  = draw_weight();
            px.last    = (k == len - 1);
            send_pixel(px, no_gaps ? 0 : draw_gap(send_calm));
        end
    endtask

    // Ratio side: draw a gap, then accept one word and check it.
    initial begin
        int     wait_cycles;
        t_ratio got;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                wait_cycles  = HOLD_CYCLES;
            end else begin
                wait_cycles = draw_gap(recv_calm);
            end
            if (wait_cycles > 0) begin
                i_ready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            got.scale    = o_scale;
            got.zero_den = o_zero_denominator;
            got.sat      = o_saturated;
            sb.check_ratio(got);
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_pattern_value = '0;
        i_slice_value   = '0;
        i_weight        = '0;
        i_last          = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed runs.
        push(256, 512, 65536, 1);                 // plain ratio of 2.0
        push(-1, 100, 65536, 1);                  // every pixel masked
        push(0, 0, 65536, 1);                     // zero values count, sums stay zero
        push(100, 100, 0, 1);                     // zero weight
        push(1, 8388607, 65536, 1);               // far above range
        push(1, 65536, 65536, 1);                 // exactly 65536.0
        push(1, 65535, 65536, 1);                 // just below the limit
        push(100, 0, 65536, 1);                   // zero numerator
        push(8388607, 8388607, 131071, 1);        // largest values and weight
        push(300, 100, 131071, 0);                // weight above 1.0
        push(-5, 7, 65536, 0);                    // pattern masked
        push(50, -8388608, 65536, 0);             // slice masked
        push(8388607, 3, 70000, 0);
        push(-8388608, -8388608, 131071, 1);      // run ends on a masked pixel
        push(100, -1, 65536, 0);
        push(200, 300, 1, 0);
        push(7, 0, 65535, 1);
        push(3, 3, 65536, 0);
        push(0, 5, 65536, 1);                     // zero pattern on the last pixel, run pattern sum nonzero

        // Random runs, mostly short, with a burst of one-pixel runs while the
        // ratio side holds off, so the result queue fills and pixels stall.
        while (sent_count < PIXEL_COUNT) begin
            if (sent_count >= PIXEL_COUNT / 2 && !hold_done) begin
                hold_done    = 1'b1;
                hold_pending = 1'b1;
                repeat (40) send_random_run(1, 1'b1);
            end else if ($urandom_range(0, 9) == 0) begin
                send_random_run($urandom_range(20, 60), 1'b0);
            end else begin
                send_random_run($urandom_range(1, 6), 1'b0);
            end
        end
        i_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            $error("%0d ratio words never arrived", sb.pending.size());
            sb.errors++;
        end

        $display("Streamed %0d pixels in %0d runs, idle gaps on both sides plus one long stall.",
                 sb.pixels, sb.runs);
        $display("Runs with zero pattern sum: %0d, saturated: %0d, in range: %0d.",
                 sb.zero_dens, sb.sats, sb.runs - sb.zero_dens - sb.sats);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
